@@ sv/tfke_pkg.sv @@
// Package for the fixed-key AES-128 tag engine.
// Holds item types, mode codes, the S-box table, round key schedules and round functions.
// No dependencies.
`timescale 1ns / 1ps

package tfke_pkg;

	typedef enum logic [1:0] {
		MODE_KDF  = 2'd0,
		MODE_ENC  = 2'd1,
		MODE_DEC  = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	localparam int          NumRounds  = 10;
	localparam logic [3:0]  UidMaxLen  = 4'd8;
	localparam logic [127:0] KdfKey  = 128'h71336275_5e74316e_71665a28_70662431;
	localparam logic [127:0] DataKey = 128'h48404346_6b526e7a_404b4174_424a7032;

	typedef struct packed {
		logic [1:0]  mode;
		logic [63:0] data_hi;
		logic [63:0] data_lo;
		logic [3:0]  uid_len;
	} in_item_t;

	typedef struct packed {
		logic [63:0] block_out_hi;
		logic [63:0] block_out_lo;
		logic [47:0] tag_key;
		logic        length_error;
	} out_item_t;

	// one pipeline stage's payload
	typedef struct packed {
		logic [127:0] blk;
		logic [1:0]   mode;
		logic         err;
	} stg_t;

	typedef logic [NumRounds:0][127:0] rk_t;

	localparam logic [7:0] Sbox [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] v);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 256; i++) begin
			if (Sbox[i] == v) r = i[7:0];
		end
		return r;
	endfunction

	function automatic rk_t expand_key(input logic [127:0] key);
		logic [43:0][31:0] w;
		logic [31:0] t;
		logic [7:0]  rcon;
		rk_t rk;
		rcon = 8'h01;
		for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {Sbox[t[23:16]] ^ rcon, Sbox[t[15:8]], Sbox[t[7:0]], Sbox[t[31:24]]};
				rcon = xt(rcon);
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r <= NumRounds; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
		return rk;
	endfunction

	localparam rk_t KdfRk  = expand_key(KdfKey);
	localparam rk_t DataRk = expand_key(DataKey);

	function automatic logic [7:0] gb(input logic [127:0] s, input int b);
		return s[127-8*b -: 8];
	endfunction

	// SubBytes, ShiftRows, MixColumns (skipped on last), AddRoundKey
	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [127:0] t, m;
		logic [7:0] a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[127-8*(c*4+i) -: 8] = Sbox[gb(s, ((c+i)%4)*4+i)];
		for (int c = 0; c < 4; c++) begin
			a0 = gb(t, c*4); a1 = gb(t, c*4+1); a2 = gb(t, c*4+2); a3 = gb(t, c*4+3);
			all = a0 ^ a1 ^ a2 ^ a3;
			m[127-8*(c*4)   -: 8] = a0 ^ all ^ xt(a0 ^ a1);
			m[127-8*(c*4+1) -: 8] = a1 ^ all ^ xt(a1 ^ a2);
			m[127-8*(c*4+2) -: 8] = a2 ^ all ^ xt(a2 ^ a3);
			m[127-8*(c*4+3) -: 8] = a3 ^ all ^ xt(a3 ^ a0);
		end
		return (last ? t : m) ^ rk;
	endfunction

	// InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns (skipped on last)
	function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
			input logic last);
		logic [127:0] t, m;
		logic [3:0][7:0] a, x2, x4, x8;
		for (int c = 0; c < 4; c++)
			for (int i = 0; i < 4; i++)
				t[127-8*(((c+i)%4)*4+i) -: 8] = inv_sbox(gb(s, c*4+i));
		t = t ^ rk;
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				a[i]  = gb(t, c*4+i);
				x2[i] = xt(a[i]);
				x4[i] = xt(x2[i]);
				x8[i] = xt(x4[i]);
			end
			for (int j = 0; j < 4; j++) begin
				// 14*a[j] ^ 11*a[j+1] ^ 13*a[j+2] ^ 9*a[j+3]
				m[127-8*(c*4+j) -: 8] =
					(x8[j] ^ x4[j] ^ x2[j]) ^
					(x8[(j+1)%4] ^ x2[(j+1)%4] ^ a[(j+1)%4]) ^
					(x8[(j+2)%4] ^ x4[(j+2)%4] ^ a[(j+2)%4]) ^
					(x8[(j+3)%4] ^ a[(j+3)%4]);
			end
		end
		return last ? t : m;
	endfunction

	// UID repeated byte-cyclically over 16 bytes; zero block for empty or long UID
	function automatic logic [127:0] uid_fill(input logic [63:0] uid, input logic [3:0] len);
		logic [127:0] r;
		logic [2:0] idx;
		for (int i = 0; i < 16; i++) begin
			case (len)
				4'd1: idx = 3'd0;
				4'd2: idx = 3'(i % 2);
				4'd3: idx = 3'(i % 3);
				4'd4: idx = 3'(i % 4);
				4'd5: idx = 3'(i % 5);
				4'd6: idx = 3'(i % 6);
				4'd7: idx = 3'(i % 7);
				default: idx = 3'(i % 8);
			endcase
			r[127-8*i -: 8] = (len == 4'd0 || len > UidMaxLen) ? 8'h00 : uid[63-8*idx -: 8];
		end
		return r;
	endfunction

endpackage

@@ sv/tag_aes128_fixed_key_engine.sv @@
// AES-128 ECB engine with fixed keys: tag key derivation, block encrypt, block decrypt.
// Pipeline of one block-prepare stage and ten round stages.
// Throughput one item per cycle while the output is accepted; each stage holds its item while the next cannot take it.
// Asynchronous reset empties the pipeline; data registers are not reset.
// Depends on tfke_pkg and tfke_round_stage.
`timescale 1ns / 1ps

module tag_aes128_fixed_key_engine import tfke_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic [NumRounds:0] vld;
	logic [NumRounds:0] rdy;
	stg_t [NumRounds:0] stg;

	logic   vld_s0;
	stg_t   item_s0;
	logic [127:0] plain;
	logic [127:0] rk0;
	logic   err;

	assign err   = (in_item.mode == MODE_KDF) && (in_item.uid_len > UidMaxLen);
	assign plain = (in_item.mode == MODE_KDF) ? uid_fill(in_item.data_hi, in_item.uid_len)
		: {in_item.data_hi, in_item.data_lo};
	assign rk0   = (in_item.mode == MODE_KDF) ? KdfRk[0]
		: (in_item.mode == MODE_DEC) ? DataRk[NumRounds] : DataRk[0];

	assign in_ready = !vld_s0 || rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (in_ready) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s0.blk  <= plain ^ rk0;
			item_s0.mode <= in_item.mode;
			item_s0.err  <= err;
		end
	end

	assign vld[0] = vld_s0;
	assign stg[0] = item_s0;

	for (genvar r = 1; r <= NumRounds; r++) begin : g_round
		tfke_round_stage #(.ROUND(r)) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld[r-1]),
			.in_ready  (rdy[r-1]),
			.in_item   (stg[r-1]),
			.out_valid (vld[r]),
			.out_ready (rdy[r]),
			.out_item  (stg[r])
		);
	end

	assign rdy[NumRounds] = out_ready;
	assign out_valid      = vld[NumRounds];

	always_comb begin
		out_item = '0;
		if (stg[NumRounds].err) begin
			out_item.length_error = 1'b1;
		end else if (stg[NumRounds].mode != MODE_NONE) begin
			out_item.block_out_hi = stg[NumRounds].blk[127:64];
			out_item.block_out_lo = stg[NumRounds].blk[63:0];
			if (stg[NumRounds].mode == MODE_KDF) out_item.tag_key = stg[NumRounds].blk[127:80];
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.length_error |->
			out_item.block_out_hi == 64'd0 && out_item.block_out_lo == 64'd0 &&
			out_item.tag_key == 48'd0)
		else $error("length error with nonzero result");

	a_tag_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.tag_key != 48'd0 |-> out_item.tag_key == out_item.block_out_hi[63:16])
		else $error("tag key differs from block head");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s0)
		else $error("accepted item not in first stage");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s0 |-> in_ready)
		else $error("empty first stage not ready");

endmodule

@@ sv/tfke_round_stage.sv @@
// One AES round as a pipeline stage: encrypt round ROUND or decrypt round NumRounds-ROUND.
// Depends on tfke_pkg for round functions and fixed key schedules.
`timescale 1ns / 1ps

module tfke_round_stage import tfke_pkg::*; #(
	parameter int ROUND = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  stg_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output stg_t out_item
);

	localparam logic LastRound = (ROUND == NumRounds);

	logic   vld_q;
	stg_t   item_q;
	logic [127:0] enc_rk;

	assign in_ready  = !vld_q || out_ready;
	assign out_valid = vld_q;
	assign out_item  = item_q;
	assign enc_rk    = (in_item.mode == MODE_KDF) ? KdfRk[ROUND] : DataRk[ROUND];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q.mode <= in_item.mode;
			item_q.err  <= in_item.err;
			if (in_item.mode == MODE_DEC) begin
				item_q.blk <= dec_round(in_item.blk, DataRk[NumRounds-ROUND], LastRound);
			end else begin
				item_q.blk <= enc_round(in_item.blk, enc_rk, LastRound);
			end
		end
	end

endmodule
